// ===== rtl/core/nie_pkg.sv =====
// Shared types and constants for the Newton interpolation evaluator.
package nie_pkg;

   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 3;
   localparam int COUNT_W  = 4;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUP = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SAT = 2'd2;

   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 4'd8;

   typedef struct packed {
      logic                     done;
      logic                     sat;
      logic signed [DATA_W-1:0] quo;
   } div_result_type;

endpackage

// ===== rtl/core/nie_ram.sv =====
// Simple dual-port synchronous memory with a registered read.
module nie_ram #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/nie_div.sv =====
// Bit-serial signed fixed-point divider with 32-bit saturation.
module nie_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [nie_pkg::DATA_W:0] dividend,
   input  logic signed [nie_pkg::DATA_W:0] divisor,
   output nie_pkg::div_result_type     result
);

   localparam int DW  = nie_pkg::DATA_W;
   localparam int NW  = DW + 1 + FRAC_BITS;
   localparam int CNW = $clog2(NW + 1);

   logic            busy_ff, busy_in;
   logic [CNW-1:0]  cnt_ff, cnt_in;
   logic [NW-1:0]   num_ff, num_in;
   logic [NW-1:0]   quo_ff, quo_in;
   logic [DW:0]     rem_ff, rem_in;
   logic [DW:0]     den_ff, den_in;
   logic            neg_ff, neg_in;
   nie_pkg::div_result_type res_ff, res_in;

   logic [DW:0]     a_mag;
   logic [DW:0]     b_mag;
   logic [DW+1:0]   rem_sh;
   logic            take;
   logic [NW-1:0]   quo_next;

   always_comb begin
      a_mag    = dividend[DW] ? (DW+1)'(0) - dividend : dividend;
      b_mag    = divisor[DW] ? (DW+1)'(0) - divisor : divisor;
      rem_sh   = {rem_ff, num_ff[NW-1]};
      take     = rem_sh >= {1'b0, den_ff};
      quo_next = {quo_ff[NW-2:0], take};

      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      res_in   = res_ff;
      res_in.done = 1'b0;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNW'(NW);
         num_in  = {a_mag, FRAC_BITS'(0)};
         quo_in  = '0;
         rem_in  = '0;
         den_in  = b_mag;
         neg_in  = dividend[DW] ^ divisor[DW];
      end else if (busy_ff) begin
         rem_in = take ? (DW+1)'(rem_sh - {1'b0, den_ff}) : rem_sh[DW:0];
         num_in = {num_ff[NW-2:0], 1'b0};
         quo_in = quo_next;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNW'(1)) begin
            busy_in     = 1'b0;
            res_in.done = 1'b1;
            if (neg_ff) begin
               if (quo_next > NW'({1'b1, {(DW-1){1'b0}}})) begin
                  res_in.sat = 1'b1;
                  res_in.quo = {1'b1, {(DW-1){1'b0}}};
               end else begin
                  res_in.sat = 1'b0;
                  res_in.quo = DW'(0) - quo_next[DW-1:0];
               end
            end else begin
               if (quo_next > NW'({1'b0, {(DW-1){1'b1}}})) begin
                  res_in.sat = 1'b1;
                  res_in.quo = {1'b0, {(DW-1){1'b1}}};
               end else begin
                  res_in.sat = 1'b0;
                  res_in.quo = quo_next[DW-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         res_ff.done <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         res_ff.done <= res_in.done;
      end
      cnt_ff     <= cnt_in;
      num_ff     <= num_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      den_ff     <= den_in;
      neg_ff     <= neg_in;
      res_ff.sat <= res_in.sat;
      res_ff.quo <= res_in.quo;
   end

   assign result = res_ff;

endmodule

// ===== rtl/core/newton_interpolation_eval.sv =====
// Newton divided-difference interpolation evaluator, top level.
// Loads write the node stores directly; an evaluation over n nodes holds req_stall high
// until its result is registered, so no new request is taken while it runs.
// The bit-serial divider, run once per divided difference, sets the rate.
// Synchronous reset clears control state and sets node_count to 8; node stores are
// undefined until written.
module newton_interpolation_eval #(
   parameter int MAX_NODES = 8,
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic [nie_pkg::INDEX_W-1:0]         req_node_index,
   input  logic signed [nie_pkg::DATA_W-1:0]   req_node_x,
   input  logic signed [nie_pkg::DATA_W-1:0]   req_node_y,
   input  logic signed [nie_pkg::DATA_W-1:0]   req_query_x,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [nie_pkg::DATA_W-1:0]   rsp_value,
   output logic [nie_pkg::STATUS_W-1:0]        rsp_status,
   input  logic                                csr_wr_en,
   input  logic [nie_pkg::COUNT_W-1:0]         csr_wr_data
);

   localparam int DW    = nie_pkg::DATA_W;
   localparam int AW    = $clog2(MAX_NODES);
   localparam int CW    = $clog2(MAX_NODES + 1) + 1;
   localparam int MW    = 2 * DW + 2;
   localparam int ACC_W = 2 * DW + 8 - FRAC_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_RD0, S_RD1, S_DIVGO, S_DIV,
      S_E0, S_E1, S_E2, S_E3, S_E4, S_E5, S_E6, S_E7, S_FIN
   } state_type;

   state_type                   state_ff, state_in;
   logic [nie_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [CW-1:0]               n_ff, n_in;
   logic [AW-1:0]               i_ff, i_in;
   logic [AW-1:0]               j_ff, j_in;
   logic [AW-1:0]               k_ff, k_in;
   logic signed [DW-1:0]        qx_ff, qx_in;
   logic signed [DW-1:0]        xlo_ff, xlo_in;
   logic signed [DW-1:0]        tlo_ff, tlo_in;
   logic signed [DW:0]          d_ff, d_in;
   logic signed [DW-1:0]        coef_ff, coef_in;
   logic signed [DW-1:0]        prod_ff, prod_in;
   logic signed [MW-1:0]        mul_ff, mul_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic                        sat_ff, sat_in;
   logic                        dup_ff, dup_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0]        rsp_value_ff, rsp_value_in;
   logic [nie_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic            xy_we;
   logic [AW-1:0]   xy_waddr;
   logic [AW-1:0]   x_raddr, y_raddr, tab_raddr, coef_raddr;
   logic [DW-1:0]   x_rd, y_rd, tab_rd, coef_rd;
   logic            tab_we, coef_we;
   logic signed [DW-1:0] src_rd;
   logic signed [DW:0]   dx, dy;
   logic            div_start;
   nie_pkg::div_result_type div_res;
   logic signed [DW:0]   mul_a, mul_b;
   logic signed [MW-1:0] mul_sh;
   logic            req_accept;

   assign req_accept = req_valid && !req_stall;
   assign xy_we      = req_accept && (req_type == nie_pkg::REQ_LOAD)
                       && (int'(req_node_index) < MAX_NODES);
   assign xy_waddr   = AW'(req_node_index);
   assign src_rd     = (j_ff == '0) ? $signed(y_rd) : $signed(tab_rd);
   assign dx         = $signed({x_rd[DW-1], x_rd}) - $signed({xlo_ff[DW-1], xlo_ff});
   assign dy         = $signed({src_rd[DW-1], src_rd}) - $signed({tlo_ff[DW-1], tlo_ff});
   assign mul_sh     = mul_ff >>> FRAC_BITS;
   assign tab_we     = (state_ff == S_DIV) && div_res.done;
   assign coef_we    = tab_we && (i_ff == '0);
   assign div_start  = (state_ff == S_DIVGO) && (dx != '0);

   nie_ram #(.DEPTH(MAX_NODES), .WIDTH(DW)) u_x_ram (
      .clock(clock), .wr_en(xy_we), .wr_addr(xy_waddr), .wr_data(req_node_x),
      .rd_addr(x_raddr), .rd_data(x_rd)
   );

   nie_ram #(.DEPTH(MAX_NODES), .WIDTH(DW)) u_y_ram (
      .clock(clock), .wr_en(xy_we), .wr_addr(xy_waddr), .wr_data(req_node_y),
      .rd_addr(y_raddr), .rd_data(y_rd)
   );

   nie_ram #(.DEPTH(MAX_NODES), .WIDTH(DW)) u_tab_ram (
      .clock(clock), .wr_en(tab_we), .wr_addr(i_ff), .wr_data(div_res.quo),
      .rd_addr(tab_raddr), .rd_data(tab_rd)
   );

   nie_ram #(.DEPTH(MAX_NODES), .WIDTH(DW)) u_coef_ram (
      .clock(clock), .wr_en(coef_we), .wr_addr(j_ff), .wr_data(div_res.quo),
      .rd_addr(coef_raddr), .rd_data(coef_rd)
   );

   nie_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(dy), .divisor(dx), .result(div_res)
   );

   always_comb begin
      x_raddr    = i_ff;
      y_raddr    = i_ff;
      tab_raddr  = i_ff;
      coef_raddr = k_ff;
      mul_a      = {prod_ff[DW-1], prod_ff};
      mul_b      = d_ff;
      unique case (state_ff)
         S_RD1: begin
            x_raddr   = AW'(i_ff + j_ff + 1'b1);
            y_raddr   = AW'(i_ff + 1'b1);
            tab_raddr = AW'(i_ff + 1'b1);
         end
         S_E0: begin
            y_raddr = '0;
         end
         S_E2: begin
            x_raddr = k_ff;
         end
         S_E6: begin
            mul_a = {coef_ff[DW-1], coef_ff};
            mul_b = {prod_ff[DW-1], prod_ff};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = csr_wr_en ? csr_wr_data : count_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      qx_in         = qx_ff;
      xlo_in        = xlo_ff;
      tlo_in        = tlo_ff;
      d_in          = d_ff;
      coef_in       = coef_ff;
      prod_in       = prod_ff;
      mul_in        = mul_ff;
      acc_in        = acc_ff;
      sat_in        = sat_ff;
      dup_in        = dup_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      req_stall     = (state_ff != S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_type == nie_pkg::REQ_EVAL)) begin
               qx_in  = req_query_x;
               i_in   = '0;
               j_in   = '0;
               k_in   = '0;
               sat_in = 1'b0;
               dup_in = 1'b0;
               if (count_ff == '0) begin
                  n_in = CW'(1);
               end else if (int'(count_ff) > MAX_NODES) begin
                  n_in = CW'(MAX_NODES);
               end else begin
                  n_in = CW'(count_ff);
               end
               if ((count_ff == '0) || (count_ff == nie_pkg::COUNT_W'(1))) begin
                  state_in = S_E0;
               end else begin
                  state_in = S_RD0;
               end
            end
         end
         S_RD0: begin
            state_in = S_RD1;
         end
         S_RD1: begin
            xlo_in   = x_rd;
            tlo_in   = src_rd;
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            if (dx == '0) begin
               dup_in   = 1'b1;
               state_in = S_FIN;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_res.done) begin
               sat_in = sat_ff | div_res.sat;
               if ((CW'(i_ff) + CW'(j_ff) + CW'(2)) < n_ff) begin
                  i_in     = AW'(i_ff + 1'b1);
                  state_in = S_RD0;
               end else if ((CW'(j_ff) + CW'(2)) < n_ff) begin
                  i_in     = '0;
                  j_in     = AW'(j_ff + 1'b1);
                  state_in = S_RD0;
               end else begin
                  state_in = S_E0;
               end
            end
         end
         S_E0: begin
            state_in = S_E1;
         end
         S_E1: begin
            acc_in   = ACC_W'($signed(y_rd));
            prod_in  = DW'(1) << FRAC_BITS;
            k_in     = '0;
            state_in = (n_ff == CW'(1)) ? S_FIN : S_E2;
         end
         S_E2: begin
            state_in = S_E3;
         end
         S_E3: begin
            d_in     = $signed({qx_ff[DW-1], qx_ff}) - $signed({x_rd[DW-1], x_rd});
            coef_in  = coef_rd;
            state_in = S_E4;
         end
         S_E4: begin
            mul_in   = mul_a * mul_b;
            state_in = S_E5;
         end
         S_E5: begin
            if ((mul_sh[MW-1:DW-1] == '0) || (mul_sh[MW-1:DW-1] == '1)) begin
               prod_in = mul_sh[DW-1:0];
            end else begin
               sat_in  = 1'b1;
               prod_in = mul_sh[MW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
            end
            state_in = S_E6;
         end
         S_E6: begin
            mul_in   = mul_a * mul_b;
            state_in = S_E7;
         end
         S_E7: begin
            acc_in = acc_ff + ACC_W'(mul_sh);
            if ((CW'(k_ff) + CW'(2)) < n_ff) begin
               k_in     = AW'(k_ff + 1'b1);
               state_in = S_E2;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (dup_ff) begin
                  rsp_value_in  = '0;
                  rsp_status_in = nie_pkg::STATUS_DUP;
               end else if ((acc_ff[ACC_W-1:DW-1] == '0) || (acc_ff[ACC_W-1:DW-1] == '1)) begin
                  rsp_value_in  = acc_ff[DW-1:0];
                  rsp_status_in = sat_ff ? nie_pkg::STATUS_SAT : nie_pkg::STATUS_OK;
               end else begin
                  rsp_value_in  = acc_ff[ACC_W-1] ? {1'b1, {(DW-1){1'b0}}}
                                                  : {1'b0, {(DW-1){1'b1}}};
                  rsp_status_in = nie_pkg::STATUS_SAT;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= nie_pkg::NODE_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff          <= n_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      qx_ff         <= qx_in;
      xlo_ff        <= xlo_in;
      tlo_ff        <= tlo_in;
      d_ff          <= d_in;
      coef_ff       <= coef_in;
      prod_ff       <= prod_in;
      mul_ff        <= mul_in;
      acc_ff        <= acc_in;
      sat_ff        <= sat_in;
      dup_ff        <= dup_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ===== verif/newton_interpolation_eval_test.sv =====
// Self-checking testbench for the Newton divided-difference interpolation evaluator.
module newton_interpolation_eval_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS      = 8;
   localparam int FRAC       = 16;
   localparam int STALL_LIMIT = 20000;
   localparam int DW         = nie_pkg::DATA_W;
   localparam int SW         = nie_pkg::STATUS_W;
   localparam int IW         = nie_pkg::INDEX_W;
   localparam int CNTW       = nie_pkg::COUNT_W;

   typedef struct {
      logic signed [DW-1:0] value;
      logic [SW-1:0]        status;
   } interp_result_type;

   class interp_scoreboard;
      longint node_x[SLOTS];
      longint node_y[SLOTS];
      int unsigned node_count;
      interp_result_type pending[$];
      int mismatches;
      int results_seen;
      int loads_seen;
      int evals_seen;
      int dups_seen;
      int sats_seen;

      function new();
         node_count = int'(nie_pkg::NODE_COUNT_RESET);
      endfunction

      function longint clamp(longint v, ref bit sat);
         if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
         end
         if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
         end
         return v;
      endfunction

      function void note_request(logic kind, logic [IW-1:0] slot,
                                 logic signed [DW-1:0] x, logic signed [DW-1:0] y,
                                 logic signed [DW-1:0] q);
         longint tab[SLOTS];
         longint coef[SLOTS];
         longint dy, dx, prod, acc;
         bit sat, dup;
         int n;
         interp_result_type r;
         sat = 1'b0;
         dup = 1'b0;
         if (kind == nie_pkg::REQ_LOAD) begin
            node_x[slot] = x;
            node_y[slot] = y;
            loads_seen++;
            return;
         end
         evals_seen++;
         n = node_count;
         if (n < 1) n = 1;
         if (n > SLOTS) n = SLOTS;
         for (int i = 0; i < n; i++) tab[i] = node_y[i];
         for (int j = 0; j + 1 < n && !dup; j++) begin
            for (int i = 0; i < n - j - 1; i++) begin
               dy = tab[i+1] - tab[i];
               dx = node_x[i+j+1] - node_x[i];
               if (dx == 0) begin
                  dup = 1'b1;
                  break;
               end
               tab[i] = clamp((dy * (64'sd1 << FRAC)) / dx, sat);
            end
            coef[j] = tab[0];
         end
         if (dup) begin
            r.value = '0;
            r.status = nie_pkg::STATUS_DUP;
            dups_seen++;
         end else begin
            acc = node_y[0];
            prod = 64'sd1 << FRAC;
            for (int i = 0; i + 1 < n; i++) begin
               prod = clamp((prod * (longint'(q) - node_x[i])) >>> FRAC, sat);
               acc += (coef[i] * prod) >>> FRAC;
            end
            acc = clamp(acc, sat);
            r.value = acc[DW-1:0];
            r.status = sat ? nie_pkg::STATUS_SAT : nie_pkg::STATUS_OK;
            if (sat) sats_seen++;
         end
         pending.insert(pending.size(), r);
      endfunction

      function void check_result(logic signed [DW-1:0] value, logic [SW-1:0] status);
         interp_result_type e;
         results_seen++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result transfer: value %h status %0d",
                                           value, status);
            return;
         end
         e = pending.pop_front();
         if (value !== e.value || status !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected value %h status %0d, got value %h status %0d",
                        e.value, e.status, value, status);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_type = nie_pkg::REQ_LOAD;
   logic [IW-1:0] req_node_index = '0;
   logic signed [DW-1:0] req_node_x = '0;
   logic signed [DW-1:0] req_node_y = '0;
   logic signed [DW-1:0] req_query_x = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [DW-1:0] rsp_value;
   logic [SW-1:0] rsp_status;
   logic csr_wr_en = 1'b0;
   logic [CNTW-1:0] csr_wr_data = '0;

   interp_scoreboard sb = new();
   bit quiet = 1'b0;
   bit hold_go = 1'b0;
   int hold_left = 0;
   int idle_cycles = 0;

   newton_interpolation_eval #(.MAX_NODES(SLOTS), .FRAC_BITS(FRAC)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_node_index(req_node_index), .req_node_x(req_node_x), .req_node_y(req_node_y),
      .req_query_x(req_query_x),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_value(rsp_value),
      .rsp_status(rsp_status),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic bit idle_now();
      return !quiet && ($urandom_range(0, 99) < 21);
   endfunction

   always @(posedge clock) begin
      if (hold_go) begin
         hold_go = 1'b0;
         hold_left = 3000;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_now();
      end
   end

   // Transfers are seen at the falling edge, before the accepting edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_type, req_node_index, req_node_x, req_node_y, req_query_x);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_value, rsp_status);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic send_req(logic kind, logic [IW-1:0] slot, logic signed [DW-1:0] x,
                           logic signed [DW-1:0] y, logic signed [DW-1:0] q);
      bit taken;
      while (idle_now()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_node_index <= slot;
      req_node_x <= x;
      req_node_y <= y;
      req_query_x <= q;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic load_node(int slot, logic signed [DW-1:0] x, logic signed [DW-1:0] y);
      send_req(nie_pkg::REQ_LOAD, slot[IW-1:0], x, y, $urandom);
   endtask

   task automatic evaluate(logic signed [DW-1:0] q);
      send_req(nie_pkg::REQ_EVAL, IW'($urandom_range(0, SLOTS - 1)), $urandom, $urandom, q);
   endtask

   task automatic set_node_count(int count);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= count[CNTW-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.node_count = int'(count[CNTW-1:0]);
   endtask

   function automatic logic signed [DW-1:0] rand_coord();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return $signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
   endfunction

   task automatic random_phase(int count, int items);
      int n;
      n = (count < 1) ? 1 : ((count > SLOTS) ? SLOTS : count);
      set_node_count(count);
      for (int k = 0; k < items; k++) begin
         if ($urandom_range(0, 9) < 7) begin
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(0, 9) == 0 && i > 0)
                  load_node(i, DW'(sb.node_x[$urandom_range(0, i - 1)]), rand_coord());
               else load_node(i, rand_coord(), rand_coord());
               k++;
            end
            evaluate(rand_coord());
         end else if ($urandom_range(0, 1) == 0) begin
            load_node($urandom_range(0, SLOTS - 1), rand_coord(), rand_coord());
         end else begin
            evaluate($urandom);
         end
      end
   endtask

   initial begin
      int counts[12] = '{1, 2, 3, 4, 8, 0, 15, 5, 2, 6, 3, 7};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_node_count(8);
      for (int i = 0; i < SLOTS; i++) load_node(i, (i - 3) * 32'sh1_8000, (i * i) * 32'sh1_0000);
      evaluate(32'sh0);
      evaluate(32'sh7FFF_FFFF);
      evaluate(32'sh8000_0000);
      evaluate(32'sh0002_4000);
      load_node(0, 32'sh8000_0000, 32'sh7FFF_FFFF);
      load_node(7, 32'sh7FFF_FFFF, 32'sh8000_0000);
      evaluate(32'sh0000_0001);
      evaluate(32'shFFFF_FFFF);
      load_node(5, 32'sh0000_0000, 32'sh0001_0000);
      load_node(3, 32'sh0000_0000, 32'sh0002_0000);
      evaluate(32'sh0001_0000);
      load_node(3, 32'sh0000_8000, 32'sh0002_0000);
      set_node_count(1);
      evaluate(32'sh1234_5678);

      for (int p = 0; p < 12; p++) begin
         quiet = (p == 4);
         random_phase(counts[p], 55);
      end
      quiet = 1'b0;

      set_node_count(2);
      load_node(0, 32'sh0000_0000, 32'sh0001_0000);
      load_node(1, 32'sh0002_0000, 32'sh0003_0000);
      hold_go = 1'b1;
      for (int i = 0; i < 40; i++) evaluate(rand_coord());

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Covered %0d loads and %0d evaluations over node counts 0 to 15;",
               sb.loads_seen, sb.evals_seen);
      $display("%0d results checked, %0d duplicate-abscissa and %0d saturated, %0d mismatches.",
               sb.results_seen, sb.dups_seen, sb.sats_seen, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
